>>> design/srtdp_pkg.sv
// Shared types and constants for the sample-rate timer plan unit.
// No dependencies; compile first.
package srtdp_pkg;

    localparam int CFG_IDX_W = 8;
    localparam int CFG_W     = 30;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    typedef logic [CFG_W-1:0]     hz_t;
    typedef logic [31:0]          req_hz_t;
    typedef logic [15:0]          timer_reg_t;
    typedef logic signed [20:0]   ppm_t;

    // configuration register indexes
    localparam cfg_idx_t CFG_TIMER_CLOCK = 8'd0;
    localparam cfg_idx_t CFG_MAX_RATE    = 8'd1;

    localparam hz_t CLOCK_RESET = 30'd72000000;
    localparam hz_t RATE_RESET  = 30'd72000000;

    localparam logic [19:0] PPM_SCALE = 20'd1000000;

endpackage

>>> design/srtdp_if.sv
// Valid/ready channel interfaces for requests and timer plans.
// Depends on srtdp_pkg.
interface srtdp_req_if;
    import srtdp_pkg::*;
    logic    valid;
    logic    ready;
    req_hz_t requested_hz;
    modport source (output valid, output requested_hz, input ready);
    modport sink (input valid, input requested_hz, output ready);
endinterface

interface srtdp_plan_if;
    import srtdp_pkg::*;
    logic       valid;
    logic       ready;
    logic       ok;
    hz_t        actual_hz;
    timer_reg_t prescaler_value;
    timer_reg_t reload_value;
    ppm_t       rate_err_ppm;
    modport source (output valid, output ok, output actual_hz, output prescaler_value,
                    output reload_value, output rate_err_ppm, input ready);
    modport sink (input valid, input ok, input actual_hz, input prescaler_value,
                  input reload_value, input rate_err_ppm, output ready);
endinterface

>>> design/srtdp_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Carries a side word along; no package dependency.
module srtdp_div #(
    parameter int NW = 31,
    parameter int DW = 30,
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          adv,
    input  logic          in_valid,
    input  logic [DW-1:0] in_rem,
    input  logic [NW-1:0] in_num,
    input  logic [DW-1:0] in_den,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [NW-1:0] out_quo,
    output logic [SW-1:0] out_side
);

    logic [NW-1:0] valid_reg;
    logic [DW-1:0] rem_reg  [0:NW-1];
    logic [NW-1:0] num_reg  [0:NW-1];
    logic [DW-1:0] den_reg  [0:NW-1];
    logic [SW-1:0] side_reg [0:NW-1];

    logic [DW-1:0] cur_rem  [0:NW-1];
    logic [NW-1:0] cur_num  [0:NW-1];
    logic [DW-1:0] cur_den  [0:NW-1];
    logic [SW-1:0] cur_side [0:NW-1];
    logic [DW:0]   trial    [0:NW-1];
    logic [DW:0]   delta    [0:NW-1];
    logic [NW-1:0] ge;
    logic [DW-1:0] rem_next [0:NW-1];
    logic [NW-1:0] num_next [0:NW-1];

    always_comb
    begin
        cur_rem[0]  = in_rem;
        cur_num[0]  = in_num;
        cur_den[0]  = in_den;
        cur_side[0] = in_side;
        for (int k = 1; k < NW; k++)
        begin
            cur_rem[k]  = rem_reg[k-1];
            cur_num[k]  = num_reg[k-1];
            cur_den[k]  = den_reg[k-1];
            cur_side[k] = side_reg[k-1];
        end
        for (int k = 0; k < NW; k++)
        begin
            // shift in the next numerator bit, subtract when it fits
            trial[k]    = {cur_rem[k], cur_num[k][NW-1]};
            delta[k]    = trial[k] - {1'b0, cur_den[k]};
            ge[k]       = (trial[k] >= {1'b0, cur_den[k]});
            rem_next[k] = ge[k] ? delta[k][DW-1:0] : trial[k][DW-1:0];
            num_next[k] = {cur_num[k][NW-2:0], ge[k]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[NW-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < NW; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                num_reg[k]  <= num_next[k];
                den_reg[k]  <= cur_den[k];
                side_reg[k] <= cur_side[k];
            end
        end
    end

    assign out_valid = valid_reg[NW-1];
    assign out_quo   = num_reg[NW-1];
    assign out_side  = side_reg[NW-1];

endmodule

>>> design/sample_rate_timer_divider_plan_unit.sv
// Top level of the sample-rate timer plan unit.
// Depends on srtdp_pkg, srtdp_if and srtdp_div.
//
// Turns a requested sample rate into timer prescaler and reload values, the
// achieved rate and the rate error in ppm. The block takes one request every
// clock while no result is held at the output, and each plan passes through
// 117 register stages: four bit-per-stage dividers in series (tick count,
// reload span, achieved rate, ppm error) plus five single stages for the
// reciprocal multiply that gives the prescale factor, the span multiply, the
// rate difference, the error multiply and the output register. The whole
// pipe stalls whenever a result is held at the output and not taken. Write
// the two configuration registers only while no request is in flight.
module sample_rate_timer_divider_plan_unit #(
    parameter longint unsigned MAX_RELOAD   = 65535,
    parameter longint unsigned MAX_PRESCALE = 65536
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  srtdp_pkg::cfg_idx_t cfg_index,
    input  srtdp_pkg::hz_t      cfg_wdata,
    srtdp_req_if.sink          req,
    srtdp_plan_if.source       plan
);
    import srtdp_pkg::*;

    localparam logic [32:0] RELOAD_SPAN  = 33'(MAX_RELOAD + 1);
    localparam logic [32:0] PRESCALE_MAX = 33'(MAX_PRESCALE);

    // floor(x / (MAX_RELOAD + 1)) for x below 2^31 as (x * RECIP) >> RSH
    localparam int              RSH         = 31 + $clog2(MAX_RELOAD + 1);
    localparam longint unsigned RECIP_FULL  = ((64'd1 << RSH) + MAX_RELOAD) / (MAX_RELOAD + 1);
    localparam logic [31:0]     RECIP       = 32'(RECIP_FULL);

    localparam int SW1 = 31;
    localparam int SW3 = 62;
    localparam int SW4 = 63;
    localparam int SW5 = 65;

    hz_t  clock_hz_reg;
    hz_t  max_rate_reg;
    logic adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_hz_reg <= CLOCK_RESET;
            max_rate_reg <= RATE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TIMER_CLOCK: clock_hz_reg <= cfg_wdata;
                CFG_MAX_RATE:    max_rate_reg <= cfg_wdata;
                default:         ;
            endcase
        end
    end

    logic out_valid_reg;
    assign adv       = !out_valid_reg || plan.ready;
    assign req.ready = adv;

    // tick count = (clock + req/2) / req
    logic        rej0;
    logic [30:0] num1;
    assign rej0 = (req.requested_hz == '0) || (req.requested_hz > {2'b00, max_rate_reg});
    assign num1 = {1'b0, clock_hz_reg} + {1'b0, req.requested_hz[30:1]};

    logic           v1;
    logic [30:0]    q1;
    logic [SW1-1:0] s1;

    srtdp_div #(.NW(31), .DW(30), .SW(SW1)) u_div_ticks (
        .clk(clk), .rst_n(rst_n), .adv(adv),
        .in_valid(req.valid), .in_rem('0), .in_num(num1),
        .in_den(req.requested_hz[29:0]),
        .in_side({rej0, req.requested_hz[29:0]}),
        .out_valid(v1), .out_quo(q1), .out_side(s1)
    );

    // prescale factor = ceil(ticks / (MAX_RELOAD + 1)) = (ticks - 1) / span + 1
    logic        rej1;
    logic [30:0] ticks_m1;
    logic [62:0] recip_prod;
    assign rej1       = s1[30] || (q1 == '0);
    assign ticks_m1   = q1 - 31'd1;
    assign recip_prod = 63'(ticks_m1) * 63'(RECIP);

    logic        f_valid_reg;
    logic        f_rej_reg;
    hz_t         f_req_reg;
    logic [30:0] f_ticks_reg;
    logic [62:0] f_prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            f_valid_reg <= v1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f_rej_reg   <= rej1;
            f_req_reg   <= s1[29:0];
            f_ticks_reg <= q1;
            f_prod_reg  <= recip_prod;
        end
    end

    logic [32:0] factor_full;
    logic        rej2;
    assign factor_full = 33'(f_prod_reg >> RSH) + 33'd1;
    assign rej2        = f_rej_reg || (factor_full > PRESCALE_MAX);

    // reload span = ticks / factor
    logic           v3;
    logic [30:0]    q3;
    logic [SW3-1:0] s3;

    srtdp_div #(.NW(31), .DW(31), .SW(SW3)) u_div_span (
        .clk(clk), .rst_n(rst_n), .adv(adv),
        .in_valid(f_valid_reg), .in_rem('0), .in_num(f_ticks_reg),
        .in_den(factor_full[30:0]),
        .in_side({rej2, f_req_reg, factor_full[30:0]}),
        .out_valid(v3), .out_quo(q3), .out_side(s3)
    );

    logic [32:0] span_full;
    logic [61:0] prod_full;
    always_comb
    begin
        span_full = {2'b00, q3};
        if (q3 == '0)
        begin
            span_full = 33'd1;
        end
        else if (span_full > RELOAD_SPAN)
        begin
            span_full = RELOAD_SPAN;
        end
        prod_full = s3[30:0] * span_full[30:0];
    end

    logic        m_valid_reg;
    logic        m_rej_reg;
    hz_t         m_req_reg;
    logic [30:0] m_factor_reg;
    logic [30:0] m_span_reg;
    logic [30:0] m_prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            m_valid_reg <= v3;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_rej_reg    <= s3[61];
            m_req_reg    <= s3[60:31];
            m_factor_reg <= s3[30:0];
            m_span_reg   <= span_full[30:0];
            m_prod_reg   <= prod_full[30:0];
        end
    end

    // achieved rate = clock / (factor * span)
    logic [30:0] factor_m1;
    logic [30:0] span_m1;
    assign factor_m1 = m_factor_reg - 31'd1;
    assign span_m1   = m_span_reg - 31'd1;

    logic           v4;
    hz_t            q4;
    logic [SW4-1:0] s4;

    srtdp_div #(.NW(30), .DW(31), .SW(SW4)) u_div_actual (
        .clk(clk), .rst_n(rst_n), .adv(adv),
        .in_valid(m_valid_reg), .in_rem('0), .in_num(clock_hz_reg), .in_den(m_prod_reg),
        .in_side({m_rej_reg, m_req_reg, factor_m1[15:0], span_m1[15:0]}),
        .out_valid(v4), .out_quo(q4), .out_side(s4)
    );

    hz_t  s4_req;
    assign s4_req = s4[61:32];

    logic       p_valid_reg;
    logic       p_rej_reg;
    hz_t        p_req_reg;
    hz_t        p_actual_reg;
    timer_reg_t p_presc_reg;
    timer_reg_t p_reload_reg;
    hz_t        p_absdiff_reg;
    logic       p_neg_reg;
    logic       p_sat_reg;

    hz_t  absdiff;
    logic neg;
    assign neg     = (q4 < s4_req);
    assign absdiff = neg ? (s4_req - q4) : (q4 - s4_req);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            p_valid_reg <= v4;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_rej_reg     <= s4[62];
            p_req_reg     <= s4_req;
            p_actual_reg  <= q4;
            p_presc_reg   <= s4[31:16];
            p_reload_reg  <= s4[15:0];
            p_absdiff_reg <= absdiff;
            p_neg_reg     <= neg;
            // error of a full request or more clips at the ppm limit
            p_sat_reg     <= (absdiff >= s4_req);
        end
    end

    logic        q_valid_reg;
    logic        q_rej_reg;
    hz_t         q_req_reg;
    hz_t         q_actual_reg;
    timer_reg_t  q_presc_reg;
    timer_reg_t  q_reload_reg;
    logic        q_neg_reg;
    logic        q_sat_reg;
    logic [49:0] q_scaled_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            q_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            q_rej_reg    <= p_rej_reg;
            q_req_reg    <= p_req_reg;
            q_actual_reg <= p_actual_reg;
            q_presc_reg  <= p_presc_reg;
            q_reload_reg <= p_reload_reg;
            q_neg_reg    <= p_neg_reg;
            q_sat_reg    <= p_sat_reg;
            q_scaled_reg <= {20'd0, p_absdiff_reg} * {30'd0, PPM_SCALE};
        end
    end

    // without saturation the quotient is below 2^20, so the top 30 bits
    // of the scaled error already sit below the divisor
    logic           v5;
    logic [19:0]    q5;
    logic [SW5-1:0] s5;

    srtdp_div #(.NW(20), .DW(30), .SW(SW5)) u_div_ppm (
        .clk(clk), .rst_n(rst_n), .adv(adv),
        .in_valid(q_valid_reg), .in_rem(q_scaled_reg[49:20]), .in_num(q_scaled_reg[19:0]),
        .in_den(q_req_reg),
        .in_side({q_rej_reg, q_actual_reg, q_presc_reg, q_reload_reg, q_neg_reg, q_sat_reg}),
        .out_valid(v5), .out_quo(q5), .out_side(s5)
    );

    logic        f_rej;
    hz_t         f_actual;
    logic [20:0] ppm_mag;
    logic [20:0] ppm_bits;
    assign f_rej    = s5[64];
    assign f_actual = s5[63:34];
    assign ppm_mag  = s5[0] ? {1'b0, PPM_SCALE} : {1'b0, q5};
    assign ppm_bits = s5[1] ? (~ppm_mag + 21'd1) : ppm_mag;

    logic       out_ok_reg;
    hz_t        out_actual_reg;
    timer_reg_t out_presc_reg;
    timer_reg_t out_reload_reg;
    logic [20:0] out_ppm_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= v5;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_ok_reg     <= !f_rej && (f_actual != '0);
            out_actual_reg <= f_rej ? '0 : f_actual;
            out_presc_reg  <= f_rej ? '0 : s5[33:18];
            out_reload_reg <= f_rej ? '0 : s5[17:2];
            out_ppm_reg    <= f_rej ? '0 : ppm_bits;
        end
    end

    assign plan.valid           = out_valid_reg;
    assign plan.ok              = out_ok_reg;
    assign plan.actual_hz       = out_actual_reg;
    assign plan.prescaler_value = out_presc_reg;
    assign plan.reload_value    = out_reload_reg;
    assign plan.rate_err_ppm    = out_ppm_reg;

`ifndef SYNTH
    a_ok_rate: assert property (@(posedge clk) disable iff (!rst_n)
        plan.valid && plan.ok |-> plan.actual_hz != '0)
        else $error("plan ok with zero achieved rate");

    a_ppm_range: assert property (@(posedge clk) disable iff (!rst_n)
        plan.valid |-> (plan.rate_err_ppm <= 21'sd1000000)
                    && (plan.rate_err_ppm >= -21'sd1000000))
        else $error("ppm error out of range");

    a_zero_rate: assert property (@(posedge clk) disable iff (!rst_n)
        plan.valid && !plan.ok && (plan.prescaler_value != '0 || plan.reload_value != '0)
        |-> plan.rate_err_ppm == -21'sd1000000)
        else $error("zero-rate plan without full negative error");
`endif

endmodule

>>> tb/srtdp_tb_if.sv
`timescale 1ns / 100ps
// Small helper package for the bench: the packed plan word.
// Depends on srtdp_pkg; channel interfaces come from design/srtdp_if.sv.
package srtdp_tb_pkg;
    import srtdp_pkg::*;

    typedef struct packed {
        logic       ok;
        hz_t        actual_hz;
        timer_reg_t prescaler_value;
        timer_reg_t reload_value;
        ppm_t       rate_err_ppm;
    } plan_t;
endpackage

>>> tb/sample_rate_timer_divider_plan_unit_tb.sv
`timescale 1ns / 100ps
// Testbench for sample_rate_timer_divider_plan_unit: drives rate requests with
// random idling, predicts each timer plan and checks results in order.
// Depends on srtdp_pkg, srtdp_if, srtdp_tb_pkg and the RTL.
module sample_rate_timer_divider_plan_unit_tb;
    import srtdp_pkg::*;
    import srtdp_tb_pkg::*;

    localparam longint unsigned RELOAD_MAX   = 65535;
    localparam longint unsigned PRESCALE_MAX = 65536;
    localparam int LATENCY     = 116;
    localparam longint LIMIT   = 2000000;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     cfg_we = 1'b0;
    cfg_idx_t cfg_index = CFG_TIMER_CLOCK;
    hz_t      cfg_wdata = '0;

    srtdp_req_if  req ();
    srtdp_plan_if plan ();

    sample_rate_timer_divider_plan_unit dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata), .req(req.sink), .plan(plan.source)
    );

    longint unsigned clock_hz = CLOCK_RESET;
    longint unsigned rate_max = RATE_RESET;
    plan_t  pending_plans[$];
    int     mismatches = 0;
    longint cycles = 0;
    bit     no_idle = 1'b0;

    initial
    begin
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic plan_t plan_for(longint unsigned rq);
        plan_t p;
        longint unsigned ticks, factor, span, actual;
        longint diff, ppm;
        p = '0;
        if (rq == 0 || rq > rate_max) return p;
        ticks = (clock_hz + rq / 2) / rq;
        if (ticks == 0) return p;
        factor = (ticks + RELOAD_MAX) / (RELOAD_MAX + 1);
        if (factor == 0) factor = 1;
        if (factor > PRESCALE_MAX) return p;
        span = ticks / factor;
        if (span == 0) span = 1;
        if (span > RELOAD_MAX + 1) span = RELOAD_MAX + 1;
        actual = clock_hz / (factor * span);
        diff = longint'(actual) - longint'(rq);
        ppm = (diff * 1000000) / longint'(rq);
        if (ppm > 1000000) ppm = 1000000;
        if (ppm < -1000000) ppm = -1000000;
        p.ok = (actual != 0);
        p.actual_hz = actual[29:0];
        p.prescaler_value = 16'(factor - 1);
        p.reload_value = 16'(span - 1);
        p.rate_err_ppm = ppm[20:0];
        return p;
    endfunction

    // result side: random backpressure, compare against oldest expectation
    initial
    begin
        plan.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && plan.valid && plan.ready)
            begin
                plan_t got, want;
                got = {plan.ok, plan.actual_hz, plan.prescaler_value,
                       plan.reload_value, plan.rate_err_ppm};
                if (pending_plans.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected plan word %h", got);
                end
                else
                begin
                    want = pending_plans.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("plan mismatch: exp ok=%0d hz=%0d psc=%0d arr=%0d ppm=%0d",
                                want.ok, want.actual_hz, want.prescaler_value,
                                want.reload_value, want.rate_err_ppm,
                                " got ok=%0d hz=%0d psc=%0d arr=%0d ppm=%0d",
                                got.ok, got.actual_hz, got.prescaler_value,
                                got.reload_value, got.rate_err_ppm);
                    end
                end
            end
            plan.ready <= no_idle || ($urandom_range(99) >= 33);
        end
    end

    // valid stays high after the accepting edge; an idle spell in the next call, or drain, drops it
    task automatic send_rate(input logic [31:0] rq);
        while (!no_idle && $urandom_range(99) < 33)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid <= 1'b1;
        req.requested_hz <= rq;
        @(posedge clk);
        while (!req.ready) @(posedge clk);
        pending_plans.push_back(plan_for(rq));
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        while (pending_plans.size() != 0) @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input longint unsigned value);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value[29:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_TIMER_CLOCK) clock_hz = value[29:0];
        else if (idx == CFG_MAX_RATE) rate_max = value[29:0];
    endtask

    function automatic logic [31:0] random_rate();
        case ($urandom_range(5))
            0: return $urandom();
            1: return $urandom_range(2000);
            2: return 32'($urandom_range(32'(rate_max)));
            3: return 32'(rate_max) + $urandom_range(3) - 1;
            default: return 32'($urandom_range(1000000));
        endcase
    endfunction

    task automatic test_directed();
        send_rate(32'd0);
        send_rate(32'd1);
        send_rate(32'd2);
        send_rate(32'd1000);
        send_rate(32'd44100);
        send_rate(32'd1000000);
        send_rate(32'd71999999);
        send_rate(32'd72000000);
        send_rate(32'd72000001);
        send_rate(32'hFFFFFFFF);
        send_rate(32'h80000000);
        send_rate(32'd48000001);
        send_rate(32'd144000001);
    endtask

    task automatic test_clock_extremes();
        write_reg(CFG_MAX_RATE, 30'h3FFFFFFF);
        write_reg(CFG_TIMER_CLOCK, 1000000000);
        send_rate(32'd1);
        send_rate(32'd7);
        send_rate(32'd999999999);
        send_rate(32'd1000000000);
        send_rate(32'd2000000000);
        send_rate(32'd3000000);
        write_reg(CFG_TIMER_CLOCK, 1);
        send_rate(32'd1);
        send_rate(32'd2);
        send_rate(32'd3);
        write_reg(CFG_TIMER_CLOCK, 0);
        send_rate(32'd1);
        write_reg(CFG_TIMER_CLOCK, 30'h3FFFFFFF);
        send_rate(32'd1);
        send_rate(32'h3FFFFFFF);
        write_reg(CFG_MAX_RATE, 1);
        send_rate(32'd1);
        send_rate(32'd2);
    endtask

    task automatic test_random(input int n);
        for (int i = 0; i < n; i++)
        begin
            no_idle = (i >= n / 3 && i < n / 2);
            send_rate(random_rate());
        end
        no_idle = 1'b0;
    endtask

    task automatic test_settings();
        write_reg(CFG_TIMER_CLOCK, 72000000);
        write_reg(CFG_MAX_RATE, 72000000);
        test_random(500);
        write_reg(CFG_TIMER_CLOCK, 1000000000);
        write_reg(CFG_MAX_RATE, 1000000000);
        test_random(400);
        // pause until everything is back before moving on
        drain();
        write_reg(CFG_TIMER_CLOCK, $urandom_range(1, 30'h3FFFFFFF));
        write_reg(CFG_MAX_RATE, $urandom_range(1, 30'h3FFFFFFF));
        test_random(300);
        write_reg(CFG_TIMER_CLOCK, $urandom_range(1, 100000));
        write_reg(CFG_MAX_RATE, $urandom_range(1, 100000));
        test_random(150);
    endtask

    initial
    begin
        req.valid = 1'b0;
        req.requested_hz = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_clock_extremes();
        test_settings();
        drain();
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
